@@ rtl/core/content_length_deframer_unit_assert.svh @@
// Assertion macros shared by the content length deframer checkers.
// Needs nothing but a clock and a reset in the scope that uses them.
`ifndef CONTENT_LENGTH_DEFRAMER_UNIT_ASSERT_SVH
`define CONTENT_LENGTH_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLCD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("content length deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("content length deframer check failed");

`endif

@@ rtl/core/clcd_pkg.sv @@
// Shared types, character codes and small lookup functions of the deframer.
// Stands alone; imported by clcd_front, clcd_queue, the top, the checker and the bench.
`timescale 1ns / 1ps

package clcd_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_DROP  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // Where the parser stands inside the current header line.
  typedef enum logic [7:0] {
    PH_LEAD   = 8'b0000_0001,
    PH_KEY    = 8'b0000_0010,
    PH_SKIP   = 8'b0000_0100,
    PH_VLEAD  = 8'b0000_1000,
    PH_VSIGN  = 8'b0001_0000,
    PH_VDIG   = 8'b0010_0000,
    PH_VTRAIL = 8'b0100_0000,
    PH_VBAD   = 8'b1000_0000
  } line_phase_t;

  // One result item as it travels from the parser to the output queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Character codes.
  localparam logic [7:0] CH_HT      = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_COLON   = 8'd58;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  // Length of the key text.
  localparam logic [3:0] KEY_LEN = 4'd14;

  // Output queue geometry.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Lower-case key text, one character per position.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // Header terminator CR LF CR LF, indexed by the bytes matched so far.
  function automatic logic [7:0] term_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_CR;
      2'd1:    ch = CH_LF;
      2'd2:    ch = CH_CR;
      default: ch = CH_LF;
    endcase
    return ch;
  endfunction

  // ASCII whitespace: HT, LF, VT, FF, CR and space.
  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_HT) && (ch <= CH_CR));
  endfunction

  // Folds ASCII upper-case letters to lower case.
  function automatic logic [7:0] to_lower(input logic [7:0] ch);
    return ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ? ch + CASE_SHIFT : ch;
  endfunction

endpackage

@@ rtl/core/clcd_stream_if.sv @@
// Valid/ready stream interfaces for the byte input and the result output.
// Depends on nothing; the payload fields are plain vectors.
`timescale 1ns / 1ps

interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

@@ rtl/core/clcd_front.sv @@
// Front end: accepts stream bytes, parses headers and counts body bytes.
// Uses clcd_pkg and clcd_in_if; pushes result items to the output queue.
`timescale 1ns / 1ps

module clcd_front #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  clcd_in_if.sink           in_stream,
  output logic              push_valid,
  input  logic              push_ready,
  output clcd_pkg::result_t push_data
);
  import clcd_pkg::*;

  // Parser and body state.
  logic                 in_body, in_body_next;
  logic [1:0]           term_match, term_match_next;
  line_phase_t          line_phase, line_phase_next;
  logic [3:0]           key_position, key_position_next;
  logic                 length_decided, length_decided_next;
  logic                 length_ok, length_ok_next;
  logic                 value_negative, value_negative_next;
  logic [LEN_WIDTH-1:0] length_accum, length_accum_next;
  logic [LEN_WIDTH-1:0] body_left, body_left_next;

  logic                 transfer;
  logic [7:0]           ch;
  logic [7:0]           ch_lower;
  logic                 ws;
  logic                 is_digit;
  logic                 done;
  logic [LEN_WIDTH+3:0] accum_times_ten;
  logic                 overflow;
  logic                 result_valid;

  assign transfer        = in_stream.valid && push_ready;
  assign in_stream.ready = push_ready;
  assign push_valid      = transfer && result_valid;

  assign ch       = in_stream.in_byte;
  assign ch_lower = to_lower(ch);
  assign ws       = is_space(ch);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign done     = (term_match == 2'd3) && (ch == CH_LF);

  // Decimal step: ten times the value plus the digit, with room for overflow.
  assign accum_times_ten = ({4'b0000, length_accum} << 3) + ({4'b0000, length_accum} << 1)
                         + (LEN_WIDTH + 4)'(ch[3:0] - CH_ZERO[3:0]);
  assign overflow = |accum_times_ten[LEN_WIDTH+3:LEN_WIDTH];

  // Next state and result for the byte on the input.
  always_comb begin
    in_body_next        = in_body;
    term_match_next     = term_match;
    line_phase_next     = line_phase;
    key_position_next   = key_position;
    length_decided_next = length_decided;
    length_ok_next      = length_ok;
    value_negative_next = value_negative;
    length_accum_next   = length_accum;
    body_left_next      = body_left;
    result_valid        = 1'b0;
    push_data           = '{kind: KIND_BODY, data: 8'd0, last: 1'b0};

    if (in_body) begin
      // Body bytes pass straight through; the count marks the final one.
      result_valid   = 1'b1;
      push_data.data = ch;
      push_data.last = (body_left <= LEN_WIDTH'(1));
      body_left_next = body_left - LEN_WIDTH'(1);
      if (body_left_next == '0) begin
        in_body_next = 1'b0;
      end
    end else begin
      // Terminator search, restarting on a CR that breaks the sequence.
      if (ch == term_char(term_match)) begin
        term_match_next = term_match + 2'd1;
      end else begin
        term_match_next = (ch == CH_CR) ? 2'd1 : 2'd0;
      end

      // Line parser.
      if (ch == CH_LF) begin
        if (!length_decided) begin
          if ((line_phase == PH_VDIG) || (line_phase == PH_VTRAIL)) begin
            length_decided_next = 1'b1;
            length_ok_next      = !(value_negative && (length_accum != '0));
          end else if ((line_phase == PH_VLEAD) || (line_phase == PH_VSIGN) ||
                       (line_phase == PH_VBAD)) begin
            length_decided_next = 1'b1;
            length_ok_next      = 1'b0;
          end
        end
        line_phase_next   = PH_LEAD;
        key_position_next = 4'd0;
      end else if (!length_decided) begin
        case (line_phase)
          PH_LEAD, PH_KEY: begin
            if (!((line_phase == PH_LEAD) && ws)) begin
              if (ch == CH_COLON) begin
                if ((line_phase == PH_KEY) && (key_position == KEY_LEN)) begin
                  line_phase_next     = PH_VLEAD;
                  value_negative_next = 1'b0;
                  length_accum_next   = '0;
                end else begin
                  line_phase_next = PH_SKIP;
                end
              end else if ((key_position < KEY_LEN) &&
                           (ch_lower == key_char(key_position))) begin
                key_position_next = key_position + 4'd1;
                line_phase_next   = PH_KEY;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end
          end
          PH_VLEAD, PH_VSIGN, PH_VDIG: begin
            if (is_digit) begin
              if (overflow) begin
                line_phase_next = PH_VBAD;
              end else begin
                length_accum_next = accum_times_ten[LEN_WIDTH-1:0];
                line_phase_next   = PH_VDIG;
              end
            end else if ((line_phase == PH_VLEAD) && ws) begin
              line_phase_next = line_phase;
            end else if ((line_phase == PH_VLEAD) &&
                         ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
              value_negative_next = (ch == CH_MINUS);
              line_phase_next     = PH_VSIGN;
            end else if ((line_phase == PH_VDIG) && ws) begin
              line_phase_next = PH_VTRAIL;
            end else begin
              line_phase_next = PH_VBAD;
            end
          end
          PH_VTRAIL: begin
            if (!ws) begin
              line_phase_next = PH_VBAD;
            end
          end
          default: begin
            line_phase_next = line_phase;
          end
        endcase
      end

      // End of header: decide between body, empty message and drop.
      if (done) begin
        if (length_decided_next && length_ok_next) begin
          if (value_negative_next || (length_accum_next == '0)) begin
            result_valid   = 1'b1;
            push_data.kind = KIND_EMPTY;
          end else begin
            in_body_next   = 1'b1;
            body_left_next = length_accum_next;
          end
        end else begin
          result_valid   = 1'b1;
          push_data.kind = KIND_DROP;
        end
        term_match_next     = 2'd0;
        line_phase_next     = PH_LEAD;
        key_position_next   = 4'd0;
        length_decided_next = 1'b0;
        length_ok_next      = 1'b0;
        value_negative_next = 1'b0;
        length_accum_next   = '0;
      end
    end
  end

  // State update on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body        <= 1'b0;
      term_match     <= 2'd0;
      line_phase     <= PH_LEAD;
      key_position   <= 4'd0;
      length_decided <= 1'b0;
      length_ok      <= 1'b0;
      value_negative <= 1'b0;
      length_accum   <= '0;
      body_left      <= '0;
    end else if (transfer) begin
      in_body        <= in_body_next;
      term_match     <= term_match_next;
      line_phase     <= line_phase_next;
      key_position   <= key_position_next;
      length_decided <= length_decided_next;
      length_ok      <= length_ok_next;
      value_negative <= value_negative_next;
      length_accum   <= length_accum_next;
      body_left      <= body_left_next;
    end
  end

endmodule

@@ rtl/core/clcd_queue.sv @@
// Back end: a two-entry result queue whose head drives the output channel.
// Uses clcd_pkg and clcd_out_if; fed by clcd_front.
`timescale 1ns / 1ps

module clcd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  clcd_pkg::result_t push_data,
  clcd_out_if.source        out_stream
);
  import clcd_pkg::*;

  result_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;
  logic                     push;
  logic                     pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;
  assign pop        = out_stream.valid && out_stream.ready;

  // The head entry is shown as long as the queue holds anything.
  assign out_stream.valid    = (count != '0);
  assign out_stream.out_kind = entries[rd_ptr].kind;
  assign out_stream.out_byte = entries[rd_ptr].data;
  assign out_stream.out_last = entries[rd_ptr].last;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/content_length_deframer_unit.sv @@
// Content length deframer: takes one byte per transfer, finds each header's
// CR LF CR LF end, reads the content-length line and then passes that many body
// bytes through, marking the last one. A header with a missing, invalid or
// negative length gives one drop item; a length of zero gives one empty item.
// The block takes one byte every cycle while the queue has room; each byte's
// parser update is combinational in the front end, and its result is written to
// the queue on its transfer. A two-entry queue sits between the parser and the
// output, so input transfers go on while the output is stalled until that
// queue fills. LEN_WIDTH sets the width of the body length (8 to 63 bits);
// longer values count as invalid. The block needs no start-up time after reset.
// Depends on clcd_pkg, clcd_stream_if, clcd_front and clcd_queue.
`timescale 1ns / 1ps

module content_length_deframer_unit #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  clcd_in_if.sink    in_stream,
  clcd_out_if.source out_stream
);
  import clcd_pkg::*;

  logic    push_valid;
  logic    push_ready;
  result_t push_data;

  // Parser and body counter.
  clcd_front #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Result queue, whose head entry drives the output.
  clcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_stream (out_stream)
  );

endmodule

@@ rtl/core/clcd_checker.sv @@
// Port-level checks of the deframer output and the bind that attaches them.
// Uses clcd_pkg and content_length_deframer_unit_assert.svh.
`timescale 1ns / 1ps

`include "content_length_deframer_unit_assert.svh"

module clcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import clcd_pkg::*;

  logic [10:0] payload;
  logic        status_item;

  // Whole output payload and a flag for drop and empty items.
  assign payload     = {out_kind, out_byte, out_last};
  assign status_item = out_valid && (out_kind != KIND_BODY);

  // Only a body byte can close a message.
  `CLCD_ASSERT_IMP(a_last_is_body, clk, rst, out_valid && out_last, out_kind == KIND_BODY)

  // Drop and empty items carry no byte and no end mark.
  `CLCD_ASSERT_IMP(a_status_clean, clk, rst, status_item, (out_byte == 8'd0) && !out_last)

  // Nothing is offered in the first cycle after reset.
  `CLCD_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !out_valid)

  // A stalled item stays offered and unchanged.
  `CLCD_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind content_length_deframer_unit clcd_checker u_clcd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_kind  (out_stream.out_kind),
  .out_byte  (out_stream.out_byte),
  .out_last  (out_stream.out_last)
);

@@ bench/testbench.sv @@
// Self-checking bench for content_length_deframer_unit: drives framed byte messages
// and compares every result transfer with a behavioral predictor of the deframer.
// Depends on clcd_pkg, clcd_stream_if and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import clcd_pkg::*;

  localparam int LEN_W = 32;
  localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;
  localparam int KEY_CHARS = 14;
  localparam string LENGTH_KEY = "content-length";
  localparam int TERM_CHARS = 4;
  localparam int RANDOM_BYTES = 1300;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_ROWS = 20;

  // One directed message: header text, body size, and the header result if it is
  // obvious from the text (drops and empty bodies).
  typedef struct {
    string head;
    int    body_len;
    bit    typed;
    kind_t kind;
  } directed_row_t;

  // Octal 015 is CR; \n is LF.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{"Content-Length: 3\015\n\015\n", 3, 1'b0, KIND_BODY},
    '{"\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"content-length: 0\015\n\015\n", 0, 1'b1, KIND_EMPTY},
    '{"CONTENT-LENGTH:-0000\015\n\015\n", 0, 1'b1, KIND_EMPTY},
    '{"Content-Length: -5\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: +\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: \t \015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: 1 2\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: 12x\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: 4294967296\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: -4294967296\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{" \t\013Content-Length:\014 +2 \t\015\n\015\n", 2, 1'b0, KIND_BODY},
    '{"Content-Length : 2\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{":Content-Length: 2\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: 9z\015\nContent-Length: 2\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Content-Length: 1\015\nContent-Length: zz\015\n\015\n", 1, 1'b0, KIND_BODY},
    '{"C\377NTENT-LENGTH: 1\015\n\015\n", 0, 1'b1, KIND_DROP},
    '{"Host: x\nContent-Type: text\015\ncontent-LENGTH:007\015\n\015\n", 7, 1'b0, KIND_BODY},
    '{"Content-Length: 2\015\015\n\015\015\n\015\n", 2, 1'b0, KIND_BODY},
    '{"Content-Length: 64\015\n\015\n", 64, 1'b0, KIND_BODY}
  };

  logic clk;
  logic rst;

  clcd_in_if  in_bus ();
  clcd_out_if out_bus ();

  content_length_deframer_unit #(
    .LEN_WIDTH(LEN_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_bus),
    .out_stream(out_bus)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Predictor state of the deframer.
  bit          in_body;
  int          term_hits;
  line_phase_t line_pos;
  int          key_hits;
  bit          len_seen;
  bit          len_valid;
  bit          len_neg;
  logic [63:0] len_value;
  logic [63:0] body_remaining;

  result_t     awaited_results[$];
  logic [7:0]  message_bytes[$];
  int          error_count;
  int          bytes_sent;
  int          traffic_phase;

  // Appends one byte to the message under construction.
  function automatic void append_byte(input logic [7:0] c);
    message_bytes.insert(message_bytes.size(), c);
  endfunction

  // Appends one result to the list of results still to arrive.
  function automatic void expect_result(input result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic void clear_header();
    term_hits = 0;
    line_pos  = PH_LEAD;
    key_hits  = 0;
    len_seen  = 1'b0;
    len_valid = 1'b0;
    len_neg   = 1'b0;
    len_value = '0;
  endfunction

  // A line end settles the length if this line was the first length line.
  function automatic void close_line();
    if (!len_seen) begin
      if (line_pos == PH_VDIG || line_pos == PH_VTRAIL) begin
        len_seen  = 1'b1;
        len_valid = !(len_neg && len_value != 0);
      end else if (line_pos != PH_LEAD && line_pos != PH_KEY && line_pos != PH_SKIP) begin
        len_seen  = 1'b1;
        len_valid = 1'b0;
      end
    end
    line_pos = PH_LEAD;
    key_hits = 0;
  endfunction

  // Advances the header line parser by one byte.
  function automatic void parse_header_char(input logic [7:0] c);
    bit          blank;
    logic [63:0] digit;
    blank = is_blank(c);
    if (c == CH_LF) begin
      close_line();
      return;
    end
    if (len_seen) begin
      return;
    end
    case (line_pos)
      PH_LEAD, PH_KEY: begin
        if (line_pos == PH_LEAD && blank) begin
          // Leading whitespace of the line is trimmed.
        end else if (c == CH_COLON) begin
          if (line_pos == PH_KEY && key_hits == KEY_CHARS) begin
            line_pos  = PH_VLEAD;
            len_neg   = 1'b0;
            len_value = '0;
          end else begin
            line_pos = PH_SKIP;
          end
        end else if (key_hits < KEY_CHARS && fold_case(c) == LENGTH_KEY[key_hits]) begin
          key_hits++;
          line_pos = PH_KEY;
        end else begin
          line_pos = PH_SKIP;
        end
      end
      PH_VLEAD, PH_VSIGN, PH_VDIG: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digit = 64'(c - CH_ZERO);
          if (len_value > (LEN_MAX - digit) / 10) begin
            line_pos = PH_VBAD;
          end else begin
            len_value = len_value * 10 + digit;
            line_pos  = PH_VDIG;
          end
        end else if (line_pos == PH_VLEAD && blank) begin
          // Leading whitespace of the value.
        end else if (line_pos == PH_VLEAD && (c == CH_PLUS || c == CH_MINUS)) begin
          len_neg  = (c == CH_MINUS);
          line_pos = PH_VSIGN;
        end else if (line_pos == PH_VDIG && blank) begin
          line_pos = PH_VTRAIL;
        end else begin
          line_pos = PH_VBAD;
        end
      end
      PH_VTRAIL: begin
        if (!blank) begin
          line_pos = PH_VBAD;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the result, if any, that one accepted byte causes.
  function automatic bit deframe_byte(input logic [7:0] c, output result_t res);
    bit done;
    res = '{kind: KIND_BODY, data: 8'h00, last: 1'b0};
    if (in_body) begin
      res.data = c;
      res.last = (body_remaining <= 1);
      body_remaining = (body_remaining - 1) & LEN_MAX;
      if (body_remaining == 0) begin
        in_body = 1'b0;
      end
      return 1'b1;
    end

    // Terminator tracking: CR LF CR LF, restarting on a stray CR.
    if (c == ((term_hits % 2 == 1) ? CH_LF : CH_CR)) begin
      term_hits++;
    end else begin
      term_hits = (c == CH_CR) ? 1 : 0;
    end
    done = (term_hits >= TERM_CHARS);
    parse_header_char(c);
    if (!done) begin
      return 1'b0;
    end

    if (len_seen && len_valid) begin
      if (len_neg || len_value == 0) begin
        res.kind = KIND_EMPTY;
      end else begin
        in_body = 1'b1;
        body_remaining = len_value;
      end
    end else begin
      res.kind = KIND_DROP;
    end
    clear_header();
    return !in_body;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
               $realtime, what, want.kind, want.data, want.last, got.kind, got.data, got.last);
    end
  endfunction

  // Sends one byte, idling at random first, and records its expected result.
  task automatic transfer_byte(input logic [7:0] value, input bit fixed_en,
                               input result_t fixed_result);
    int      idle_pct;
    result_t res;
    bit      produced;
    idle_pct = (traffic_phase == 0) ? 10 : (traffic_phase == 1) ? 64 : 0;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= value;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    produced = deframe_byte(value, res);
    if (fixed_en) begin
      expect_result(fixed_result);
    end else if (produced) begin
      expect_result(res);
    end
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'($urandom_range(97, 122));
    return $urandom_range(0, 1) ? c - 8'd32 : c;
  endfunction

  task automatic add_blanks(input int most);
    repeat ($urandom_range(0, most)) begin
      case ($urandom_range(0, 3))
        0:       append_byte(CH_HT);
        1:       append_byte(8'd11);
        2:       append_byte(8'd12);
        default: append_byte(CH_SPACE);
      endcase
    end
  endtask

  // A header line that is not the length line, near misses of the key included.
  task automatic add_other_line();
    add_blanks(1);
    case ($urandom_range(0, 7))
      0: add_text("content-lengt");
      1: add_text("Content-Lengthx");
      2: append_byte(CH_COLON);
      default: begin
        repeat ($urandom_range(1, 10)) begin
          append_byte($urandom_range(0, 5) ? random_letter() : CH_MINUS);
        end
      end
    endcase
    if ($urandom_range(0, 7) != 0) begin
      append_byte(CH_COLON);
    end
    repeat ($urandom_range(0, 10)) begin
      append_byte($urandom_range(0, 15) ? 8'($urandom_range(32, 126))
                                        : 8'($urandom_range(128, 255)));
    end
    if ($urandom_range(0, 4) != 0) begin
      append_byte(CH_CR);
    end
    append_byte(CH_LF);
  endtask

  task automatic add_length_key();
    logic [7:0] c;
    for (int i = 0; i < KEY_CHARS; i++) begin
      c = LENGTH_KEY[i];
      if (c != CH_MINUS && $urandom_range(0, 1)) begin
        c = c - 8'd32;
      end
      append_byte(c);
    end
  endtask

  // Value text of a length line; len is the body size it announces.
  task automatic add_length_value(output int len);
    int pick;
    int n;
    len = 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 3) == 0) begin
        append_byte(CH_PLUS);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) append_byte(CH_ZERO);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      add_text($sformatf("%0d", n));
      len = n;
    end else if (pick < 65) begin
      case ($urandom_range(0, 2))
        0:       append_byte(CH_PLUS);
        1:       append_byte(CH_MINUS);
        default: begin
        end
      endcase
      repeat ($urandom_range(1, 3)) append_byte(CH_ZERO);
    end else if (pick < 72) begin
      append_byte(CH_MINUS);
      add_text($sformatf("%0d", $urandom_range(1, 999)));
    end else if (pick < 76) begin
      append_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    end else if (pick < 80) begin
      // Empty value.
    end else if (pick < 85) begin
      add_text($sformatf("%0d %0d", $urandom_range(0, 99), $urandom_range(0, 99)));
    end else if (pick < 90) begin
      add_text($sformatf("%0d", $urandom_range(0, 99)));
      append_byte(random_letter());
    end else if (pick < 95) begin
      // Ten digits or more, always above the length width.
      if ($urandom_range(0, 1)) begin
        append_byte(CH_MINUS);
      end
      append_byte(CH_ZERO + 8'($urandom_range(5, 9)));
      repeat ($urandom_range(9, 11)) append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      add_text("4294967296");
    end
  endtask

  // A complete message: header lines, terminator, then the body it announces.
  task automatic build_message();
    int lines;
    int length_at;
    int body_len;
    int ignored_len;
    bit has_length;
    message_bytes.delete();
    body_len   = 0;
    lines      = $urandom_range(0, 3);
    has_length = ($urandom_range(0, 99) < 88);
    length_at  = $urandom_range(0, lines);
    for (int n = 0; n <= lines; n++) begin
      if (n != length_at) begin
        add_other_line();
      end else if (has_length) begin
        add_blanks(2);
        add_length_key();
        if ($urandom_range(0, 19) == 0) begin
          append_byte(CH_SPACE);
        end
        append_byte(CH_COLON);
        add_blanks(2);
        add_length_value(body_len);
        add_blanks(2);
        append_byte(CH_CR);
        append_byte(CH_LF);
      end
    end
    // A later length line in the same header is ignored.
    if (has_length && $urandom_range(0, 5) == 0) begin
      add_text("Content-Length:");
      add_length_value(ignored_len);
      append_byte(CH_CR);
      append_byte(CH_LF);
    end
    append_byte(CH_CR);
    append_byte(CH_LF);
    repeat (body_len) append_byte(8'($urandom));
  endtask

  // Random noise, rich in CR, LF and colons.
  task automatic build_noise();
    message_bytes.delete();
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(0, 4))
        0:       append_byte(CH_CR);
        1:       append_byte(CH_LF);
        2:       append_byte(CH_COLON);
        default: append_byte(8'($urandom));
      endcase
    end
  endtask

  // Output side: random stalls and the check of every result transfer.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    int      stall_pct;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{kind: kind_t'(out_bus.out_kind), data: out_bus.out_byte,
                last: out_bus.out_last};
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (want.kind != got.kind || want.data != got.data || want.last != got.last) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      stall_pct = (traffic_phase == 0) ? 64 : (traffic_phase == 1) ? 10 : 0;
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus: directed messages first, then random traffic in three pacing phases.
  initial begin
    int random_start;
    rst            = 1'b1;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = 8'h00;
    out_bus.ready  = 1'b0;
    traffic_phase  = 0;
    error_count    = 0;
    bytes_sent     = 0;
    in_body        = 1'b0;
    body_remaining = '0;
    clear_header();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int k = 0; k < directed_rows[r].head.len(); k++) begin
        transfer_byte(directed_rows[r].head[k],
                      directed_rows[r].typed && (k == directed_rows[r].head.len() - 1),
                      '{kind: directed_rows[r].kind, data: 8'h00, last: 1'b0});
      end
      for (int k = 0; k < directed_rows[r].body_len; k++) begin
        transfer_byte((k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom), 1'b0, '0);
      end
    end

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      traffic_phase = (bytes_sent - random_start) * 3 / RANDOM_BYTES;
      if ($urandom_range(0, 99) < 80) begin
        build_message();
      end else if ($urandom_range(0, 1)) begin
        // Message cut short in its header or body.
        build_message();
        repeat ($urandom_range(1, 8)) begin
          if (message_bytes.size() > 0) begin
            void'(message_bytes.pop_back());
          end
        end
      end else begin
        build_noise();
      end
      foreach (message_bytes[i]) begin
        transfer_byte(message_bytes[i], 1'b0, '0);
      end
    end
    in_bus.valid <= 1'b0;

    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
